### src/edge_clamped_box_blur_defines.svh
// Assertion macros used by the box blur top level.
`ifndef EDGE_CLAMPED_BOX_BLUR_DEFINES_SVH
`define EDGE_CLAMPED_BOX_BLUR_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define ECBB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define ECBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ecbb_pkg.sv
// Package: grid geometry, widths, register indexes, action codes, states and divider interface types.
package ecbb_pkg;

    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 64;
    localparam int MAX_RADIUS = 7;

    localparam int ADDR_W = $clog2(GRID_COLS * GRID_ROWS);
    localparam int CNT_W  = 8;
    localparam int SUM_W  = 24;
    localparam int MAG_W  = SUM_W - 1;
    localparam int MAX_CELLS = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_COLS   = 2'd1;
    localparam logic [1:0] CFG_ROWS   = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MAG_W-1:0] quotient;
    } div_rsp_t;

endpackage

### src/ecbb_divider.sv
// Restoring divider: one quotient bit per cycle, unsigned window sum by cell count.
module ecbb_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  ecbb_pkg::div_req_t req,
    output ecbb_pkg::div_rsp_t rsp
);
    import ecbb_pkg::*;

    localparam int ITER_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0]  dvd_reg;
    logic [CNT_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              q_bit;

    always_comb begin
        rem_shift = {rem_reg, dvd_reg[MAG_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        q_bit     = rem_shift >= {1'b0, dsr_reg};
        rem_next  = q_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(MAG_W);
            end else if (busy_reg) begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == ITER_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient bits shift in behind the dividend bits.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[MAG_W-2:0], q_bit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

### src/edge_clamped_box_blur.sv
// Top level: height grid memory, window scan sequencer and rounded mean output.
//
// Use: items arrive on the s_ channel. s_tuser is the action: a write stores
// s_tdata height at (col, row); a query returns one result on the m_ channel
// with the rounded mean of the clipped (2*radius+1)^2 window, the number of
// cells averaged and an out-of-range flag in m_tuser.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Timing: a write is taken while the block is idle. A query outside the grid in
// use goes straight to the finish step, which loads its result. A query inside
// reads the window one cell per cycle from the single grid memory read port,
// then passes through a drain step, a divider load step, the bit-serial divider
// and a finish step that loads the result into the output register. s_tready
// stays low from the query's acceptance until the block returns to idle after
// that finish step.
// A finished result waits in the output register; writes are still taken
// meanwhile, and a following query stalls in its last step until the
// receiver takes the waiting result.
// Reset (aresetn low, synchronous) restores radius 1 and a 64 x 64 grid and
// empties the output; the grid contents are not cleared.
module edge_clamped_box_blur (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // col[5:0], row[11:6], height[27:12], zero
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // blurred[15:0], window_count[23:16]
    output logic        m_tuser    // out_of_range
);
    import ecbb_pkg::*;

    `include "edge_clamped_box_blur_defines.svh"

    logic [2:0] radius_reg;
    logic [6:0] cols_reg;
    logic [6:0] rows_reg;

    state_t state_reg, state_next;

    logic [5:0]       in_col;
    logic [5:0]       in_row;
    logic [15:0]      in_height;
    logic             in_acc;
    logic [6:0]       nc;
    logic [6:0]       nr;
    logic [2:0]       rad;
    logic             in_grid;
    logic [6:0]       col_far;
    logic [6:0]       row_far;

    logic [5:0]       c0_reg, c1_reg, r1_reg;
    logic [5:0]       col_reg, row_reg;
    logic [CNT_W-1:0] count_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic             oor_reg;
    logic             rd_valid_reg;
    logic [15:0]      rd_data_reg;
    logic [15:0]      mem [GRID_COLS*GRID_ROWS];
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic             wr_en;
    logic             sum_neg;
    logic [MAG_W-1:0] sum_mag;
    logic [15:0]      mean;
    logic             slot_free;

    logic             m_tvalid_reg;
    logic [15:0]      blurred_reg;
    logic [CNT_W-1:0] wcount_reg;
    logic             m_oor_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_col    = s_tdata[5:0];
    assign in_row    = s_tdata[11:6];
    assign in_height = s_tdata[27:12];
    assign in_acc    = s_tvalid && s_tready;

    always_comb begin
        nc      = (cols_reg > 7'(GRID_COLS)) ? 7'(GRID_COLS) : cols_reg;
        nr      = (rows_reg > 7'(GRID_ROWS)) ? 7'(GRID_ROWS) : rows_reg;
        rad     = (radius_reg > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : radius_reg;
        in_grid = ({1'b0, in_col} < nc) && ({1'b0, in_row} < nr);
        col_far = {1'b0, in_col} + {4'b0, rad};
        row_far = {1'b0, in_row} + {4'b0, rad};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 3'd1;
            cols_reg   <= 7'(GRID_COLS);
            rows_reg   <= 7'(GRID_ROWS);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RADIUS: radius_reg <= cfg_wdata[2:0];
                CFG_COLS:   cols_reg   <= cfg_wdata;
                CFG_ROWS:   rows_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Grid memory: one write port, one registered read port.
    assign wr_en   = in_acc && (s_tuser == ACT_WRITE) && in_grid;
    assign wr_addr = ADDR_W'(in_row) * ADDR_W'(GRID_COLS) + ADDR_W'(in_col);
    assign rd_addr = ADDR_W'(row_reg) * ADDR_W'(GRID_COLS) + ADDR_W'(col_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_height;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        s_tready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_mag + MAG_W'(count_reg >> 1);
        div_req.divisor  = count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == ACT_QUERY) begin
                    state_next = in_grid ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (col_reg == c1_reg && row_reg == r1_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:    state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: begin
                div_req.start = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_SCAN);
            if (state_reg == ST_FINISH && slot_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Window bounds, scan position and running sum.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_acc) begin
            c0_reg    <= (in_col >= 6'(rad)) ? in_col - 6'(rad) : 6'd0;
            col_reg   <= (in_col >= 6'(rad)) ? in_col - 6'(rad) : 6'd0;
            row_reg   <= (in_row >= 6'(rad)) ? in_row - 6'(rad) : 6'd0;
            c1_reg    <= (col_far < nc) ? col_far[5:0] : 6'(nc - 7'd1);
            r1_reg    <= (row_far < nr) ? row_far[5:0] : 6'(nr - 7'd1);
            count_reg <= '0;
            sum_reg   <= '0;
            oor_reg   <= !in_grid;
        end else begin
            if (state_reg == ST_SCAN) begin
                count_reg <= count_reg + 1'b1;
                if (col_reg == c1_reg) begin
                    col_reg <= c0_reg;
                    row_reg <= row_reg + 1'b1;
                end else begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (rd_valid_reg) begin
                sum_reg <= sum_reg + SUM_W'($signed(rd_data_reg));
            end
        end
    end

    assign sum_neg = sum_reg[SUM_W-1];
    assign sum_mag = sum_neg ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
    assign mean    = sum_neg ? 16'(-div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];

    ecbb_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && slot_free) begin
            blurred_reg <= oor_reg ? 16'd0 : mean;
            wcount_reg  <= oor_reg ? '0 : count_reg;
            m_oor_reg   <= oor_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {wcount_reg, blurred_reg};
    assign m_tuser  = m_oor_reg;

    `ECBB_ASSERT_SAME(a_scan_bound, state_reg == ST_SCAN, count_reg < CNT_W'(MAX_CELLS), "scan overran the window")
    `ECBB_ASSERT_SAME(a_oor_zero, m_tvalid && m_tuser, m_tdata == 24'd0, "out-of-range result not zero")
    `ECBB_ASSERT_SAME(a_count_nonzero, m_tvalid && !m_tuser, m_tdata[23:16] != 8'd0, "empty window")
    `ECBB_ASSERT_NEXT(a_div_start, div_req.start, div_rsp.busy && state_reg == ST_DIVIDE, "divider not started")

endmodule

### test/edge_clamped_box_blur_tb.sv
// Testbench for the edge-clamped box blur: height grid writes and window mean queries.
`timescale 1ns / 1ps

module edge_clamped_box_blur_tb;
    import ecbb_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int QUIET_CYCLES = 300;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int RAND_ITEMS   = 24;
    localparam int HOLD_AT      = 12;
    localparam int FILL_SIDE    = 16;
    localparam logic [15:0] FILL_HEIGHT = 16'h7FFF;

    typedef struct packed {
        logic [15:0] blurred;
        logic [7:0]  count;
        logic        oor;
    } mean_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_QUERY,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [15:0] value;
        logic        typed;
        mean_t       want;
    } stim_row_t;

    localparam mean_t NO_MEAN  = '0;
    localparam mean_t OOR_MEAN = '{16'h0000, 8'd0, 1'b1};

    // Cells read by this table are preloaded with FILL_HEIGHT before it runs.
    localparam stim_row_t DIRECTED [37] = '{
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, '{16'h7FFF, 8'd4,   1'b0}},
        '{ROW_QUERY, CFG_RADIUS, 6'd63, 6'd63, 16'h0000, 1'b1, '{16'h7FFF, 8'd4,   1'b0}},
        '{ROW_QUERY, CFG_RADIUS, 6'd10, 6'd12, 16'h0000, 1'b1, '{16'h7FFF, 8'd9,   1'b0}},
        '{ROW_CFG,   CFG_RADIUS, 6'd0,  6'd0,  16'd7,    1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, '{16'h7FFF, 8'd64,  1'b0}},
        '{ROW_QUERY, CFG_RADIUS, 6'd8,  6'd8,  16'h0000, 1'b1, '{16'h7FFF, 8'd225, 1'b0}},
        '{ROW_WRITE, CFG_RADIUS, 6'd8,  6'd8,  16'h8000, 1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd9,  6'd8,  16'h8000, 1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd8,  6'd8,  16'h0000, 1'b0, NO_MEAN},
        '{ROW_CFG,   CFG_RADIUS, 6'd0,  6'd0,  16'd0,    1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd8,  6'd8,  16'h0000, 1'b1, '{16'h8000, 8'd1,   1'b0}},
        // column count above the grid saturates
        '{ROW_CFG,   CFG_COLS,   6'd0,  6'd0,  16'd127,  1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd63, 6'd0,  16'h0000, 1'b1, '{16'h7FFF, 8'd1,   1'b0}},
        '{ROW_CFG,   CFG_COLS,   6'd0,  6'd0,  16'd10,   1'b0, NO_MEAN},
        '{ROW_CFG,   CFG_ROWS,   6'd0,  6'd0,  16'd5,    1'b0, NO_MEAN},
        // write outside the grid in use must leave the cell alone
        '{ROW_WRITE, CFG_RADIUS, 6'd10, 6'd0,  16'h1234, 1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd10, 6'd0,  16'h0000, 1'b1, OOR_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd5,  16'h0000, 1'b1, OOR_MEAN},
        '{ROW_CFG,   CFG_RADIUS, 6'd0,  6'd0,  16'd2,    1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd9,  6'd4,  16'h0000, 1'b0, NO_MEAN},
        // empty grid: everything is out of range
        '{ROW_CFG,   CFG_COLS,   6'd0,  6'd0,  16'd0,    1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, OOR_MEAN},
        '{ROW_CFG,   CFG_COLS,   6'd0,  6'd0,  16'd64,   1'b0, NO_MEAN},
        '{ROW_CFG,   CFG_ROWS,   6'd0,  6'd0,  16'd64,   1'b0, NO_MEAN},
        '{ROW_CFG,   CFG_RADIUS, 6'd0,  6'd0,  16'd0,    1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd10, 6'd0,  16'h0000, 1'b1, '{16'h7FFF, 8'd1,   1'b0}},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, '{16'h7FFF, 8'd1,   1'b0}},
        // half-way ties round away from zero on both signs
        '{ROW_CFG,   CFG_RADIUS, 6'd0,  6'd0,  16'd1,    1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd0,  6'd0,  16'h0001, 1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd1,  6'd0,  16'h0001, 1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd0,  6'd1,  16'h0000, 1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd1,  6'd1,  16'h0000, 1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, '{16'h0001, 8'd4,   1'b0}},
        '{ROW_WRITE, CFG_RADIUS, 6'd0,  6'd0,  16'hFFFF, 1'b0, NO_MEAN},
        '{ROW_WRITE, CFG_RADIUS, 6'd1,  6'd0,  16'hFFFF, 1'b0, NO_MEAN},
        '{ROW_QUERY, CFG_RADIUS, 6'd0,  6'd0,  16'h0000, 1'b1, '{16'hFFFF, 8'd4,   1'b0}}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = CFG_RADIUS;
    logic [6:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = ACT_WRITE;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    // Predictor copy of the block's registers and grid
    logic [2:0]  radius_q = 3'd1;
    logic [6:0]  cols_q   = 7'd64;
    logic [6:0]  rows_q   = 7'd64;
    logic [15:0] heights_seen [GRID_COLS*GRID_ROWS];
    // cells that hold a stored height; a query may only read these
    bit          cell_written [GRID_COLS*GRID_ROWS];

    mean_t pending_means [$];
    mean_t front_mean;
    int    mismatches = 0;
    int    send_idle  = 0;
    int    recv_idle  = 0;

    edge_clamped_box_blur i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    function automatic int cols_eff();
        return (cols_q > GRID_COLS) ? GRID_COLS : int'(cols_q);
    endfunction

    function automatic int rows_eff();
        return (rows_q > GRID_ROWS) ? GRID_ROWS : int'(rows_q);
    endfunction

    // Rounded mean of the clipped window around (c, r), ties away from zero.
    function automatic mean_t window_mean(input logic [5:0] c, input logic [5:0] r);
        int     nc, nr, rad, ci, ri, x0, x1, y0, y1, x, y, cnt;
        longint acc, mag, q;
        mean_t  m;
        nc  = cols_eff();
        nr  = rows_eff();
        rad = int'(radius_q);
        ci  = int'(c);
        ri  = int'(r);
        m   = '0;
        acc = 0;
        cnt = 0;
        if (ci >= nc || ri >= nr) begin
            m.oor = 1'b1;
            return m;
        end
        x0 = (ci >= rad) ? ci - rad : 0;
        y0 = (ri >= rad) ? ri - rad : 0;
        x1 = (ci + rad < nc) ? ci + rad : nc - 1;
        y1 = (ri + rad < nr) ? ri + rad : nr - 1;
        for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
                acc += $signed(heights_seen[y*GRID_COLS + x]);
                cnt++;
            end
        end
        mag = (acc < 0) ? -acc : acc;
        q   = (mag + cnt / 2) / cnt;
        m.blurred = (acc < 0) ? 16'(-q) : 16'(q);
        m.count   = 8'(cnt);
        return m;
    endfunction

    // True when a query at (c, r) reads only written cells, or none at all.
    function automatic bit window_written(input logic [5:0] c, input logic [5:0] r);
        int nc, nr, rad, ci, ri, x, y;
        nc  = cols_eff();
        nr  = rows_eff();
        rad = int'(radius_q);
        ci  = int'(c);
        ri  = int'(r);
        if (ci >= nc || ri >= nr)
            return 1'b1;
        for (y = (ri >= rad) ? ri - rad : 0; y <= ri + rad && y < nr; y++) begin
            for (x = (ci >= rad) ? ci - rad : 0; x <= ci + rad && x < nc; x++) begin
                if (!cell_written[y*GRID_COLS + x])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one item, wait for its handshake, then update the prediction.
    task automatic send_item(input logic act, input logic [5:0] c, input logic [5:0] r,
                             input logic [15:0] h, input logic typed, input mean_t want);
        mean_t next_mean;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, h, r, c};
        do @(posedge aclk); while (!s_tready);
        if (act == ACT_WRITE) begin
            if (int'(c) < cols_eff() && int'(r) < rows_eff()) begin
                heights_seen[int'(r)*GRID_COLS + int'(c)] = h;
                cell_written[int'(r)*GRID_COLS + int'(c)] = 1'b1;
            end
        end else begin
            next_mean     = typed ? want : window_mean(c, r);
            pending_means = {pending_means, next_mean};
        end
    endtask

    // Drop valid, wait for every expected mean, then let a query in flight finish.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_q = val[2:0];
            CFG_COLS:   cols_q   = val;
            CFG_ROWS:   rows_q   = val;
            default: ;
        endcase
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_means.size() == 0) begin
                report_mismatch("unexpected result", int'(m_tdata), 0);
            end else begin
                front_mean = pending_means.pop_front();
                if (m_tdata[15:0] !== front_mean.blurred)
                    report_mismatch("blurred", int'(m_tdata[15:0]), int'(front_mean.blurred));
                if (m_tdata[23:16] !== front_mean.count)
                    report_mismatch("window_count", int'(m_tdata[23:16]),
                                    int'(front_mean.count));
                if (m_tuser !== front_mean.oor)
                    report_mismatch("out_of_range", int'(m_tuser), int'(front_mean.oor));
            end
        end
    end

    initial begin : stimulus
        int          i, k, n, mode, nc, nr;
        logic [5:0]  c, r;
        logic [2:0]  rad;
        logic [6:0]  cw, rw;
        logic        act;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 27;
        recv_idle = 49;

        // Preload the corner block, the far corner and the far end of row 0
        for (i = 0; i < FILL_SIDE*FILL_SIDE; i++)
            send_item(ACT_WRITE, 6'(i % FILL_SIDE), 6'(i / FILL_SIDE), FILL_HEIGHT,
                      1'b0, NO_MEAN);
        for (i = 0; i < 4; i++)
            send_item(ACT_WRITE, 6'(62 + i % 2), 6'(62 + i / 2), FILL_HEIGHT,
                      1'b0, NO_MEAN);
        send_item(ACT_WRITE, 6'd63, 6'd0, FILL_HEIGHT, 1'b0, NO_MEAN);

        for (i = 0; i < $size(DIRECTED); i++) begin
            case (DIRECTED[i].kind)
                ROW_CFG: begin
                    drain_results();
                    set_reg(DIRECTED[i].reg_idx, DIRECTED[i].value[6:0]);
                end
                ROW_WRITE: begin
                    send_item(ACT_WRITE, DIRECTED[i].col, DIRECTED[i].row,
                              DIRECTED[i].value, 1'b0, NO_MEAN);
                end
                default: begin
                    send_item(ACT_QUERY, DIRECTED[i].col, DIRECTED[i].row,
                              DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
                end
            endcase
        end

        for (mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 27 : (mode == 1) ? 49 : 0;
            recv_idle = (mode == 0) ? 49 : (mode == 1) ? 27 : 0;
            for (k = 0; k < 3; k++) begin
                case (3*mode + k)
                    0: begin rad = 3'd7; cw = 7'd64;  rw = 7'd64;  end
                    1: begin rad = 3'd0; cw = 7'd1;   rw = 7'd1;   end
                    2: begin rad = 3'd7; cw = 7'd127; rw = 7'd127; end
                    3: begin rad = 3'd3; cw = 7'd64;  rw = 7'd2;   end
                    default: begin
                        rad = 3'($urandom_range(0, 7));
                        cw  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(1, 64));
                        rw  = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(1, 64));
                    end
                endcase
                drain_results();
                set_reg(CFG_RADIUS, {4'b0, rad});
                set_reg(CFG_COLS, cw);
                set_reg(CFG_ROWS, rw);
                for (n = 0; n < RAND_ITEMS; n++) begin
                    // hold the sender until every result is back
                    if (n == HOLD_AT)
                        drain_results();
                    nc = cols_eff();
                    nr = rows_eff();
                    if (nc > 0 && nr > 0 && $urandom_range(0, 4) != 0) begin
                        c = 6'($urandom_range(0, ((nc < FILL_SIDE) ? nc : FILL_SIDE) - 1));
                        r = 6'($urandom_range(0, ((nr < FILL_SIDE) ? nr : FILL_SIDE) - 1));
                    end else begin
                        c = 6'($urandom_range(0, 63));
                        r = 6'($urandom_range(0, 63));
                    end
                    act = $urandom_range(0, 1) ? ACT_QUERY : ACT_WRITE;
                    // store instead where the window would reach an unwritten cell
                    if (act == ACT_QUERY && !window_written(c, r))
                        act = ACT_WRITE;
                    send_item(act, c, r, 16'($urandom), 1'b0, NO_MEAN);
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
